// ===== design/rws_pkg.sv =====
// Shared types, constants and the control store of the roulette wheel selector.
package rws_pkg;

	localparam int MAX_SLOTS_DEF   = 64;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int DRAW_BITS       = 14;
	localparam int POP_BITS        = 7;
	localparam int SLOT_BITS       = 6;
	localparam int FIT_BITS        = 16;
	localparam int DRAW_SCALE      = 10000;
	localparam logic [POP_BITS-1:0] POP_RESET = 7'd64;

	// Request type codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_DRAW  = 1'b1;

	// Sequencer step addresses
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOT_FIRST,
		ST_TOT_LOOP,
		ST_TGT,
		ST_SRCH_FIRST,
		ST_SRCH_ACC,
		ST_SRCH_CMP,
		ST_FINISH
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_DRAW,
		C_EMPTY,
		C_LAST,
		C_ZERO,
		C_HIT,
		C_BUSY
	} cond_t;

	// Store read operations; applied only when the jump is not taken
	typedef enum logic [1:0] {
		RD_NONE,
		RD_POST,
		RD_HERE,
		RD_PRE
	} rd_op_t;

	typedef struct packed {
		cond_t  cond;
		step_t  jump_to;
		step_t  next;
		logic   in_ready;
		rd_op_t rd_op;
		logic   tot_acc;
		logic   tgt_load;
		logic   cum_acc;
		logic   out_load;
	} uword_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '0;
		unique case (s)
			ST_IDLE: begin
				w = '{cond: C_DRAW, jump_to: ST_TOT_FIRST, next: ST_IDLE, in_ready: 1'b1,
					rd_op: RD_NONE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_TOT_FIRST: begin
				w = '{cond: C_EMPTY, jump_to: ST_FINISH, next: ST_TOT_LOOP, in_ready: 1'b0,
					rd_op: RD_POST, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_TOT_LOOP: begin
				w = '{cond: C_LAST, jump_to: ST_TGT, next: ST_TOT_LOOP, in_ready: 1'b0,
					rd_op: RD_POST, tot_acc: 1'b1, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_TGT: begin
				w = '{cond: C_ZERO, jump_to: ST_FINISH, next: ST_SRCH_FIRST, in_ready: 1'b0,
					rd_op: RD_NONE, tot_acc: 1'b0, tgt_load: 1'b1, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_SRCH_FIRST: begin
				w = '{cond: C_NEVER, jump_to: ST_SRCH_ACC, next: ST_SRCH_ACC, in_ready: 1'b0,
					rd_op: RD_HERE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_SRCH_ACC: begin
				w = '{cond: C_NEVER, jump_to: ST_SRCH_CMP, next: ST_SRCH_CMP, in_ready: 1'b0,
					rd_op: RD_NONE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b1,
					out_load: 1'b0};
			end
			ST_SRCH_CMP: begin
				w = '{cond: C_HIT, jump_to: ST_FINISH, next: ST_SRCH_ACC, in_ready: 1'b0,
					rd_op: RD_PRE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
			ST_FINISH: begin
				w = '{cond: C_BUSY, jump_to: ST_FINISH, next: ST_IDLE, in_ready: 1'b0,
					rd_op: RD_NONE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b1};
			end
			default: begin
				w = '{cond: C_NEVER, jump_to: ST_IDLE, next: ST_IDLE, in_ready: 1'b0,
					rd_op: RD_NONE, tot_acc: 1'b0, tgt_load: 1'b0, cum_acc: 1'b0,
					out_load: 1'b0};
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/rws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/roulette_wheel_selector.sv =====
// Roulette wheel selector: weight store plus microcoded total-and-search sequencer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   in       | in_valid / in_stall  | req_type, slot_index, fitness_weight, draw_value
//   out      | out_valid / out_stall| selected_slot, zero_total
//   cfg      | cfg_wr_en            | cfg_wr_data (population_count)
//
// A write beat is accepted in the idle step. A draw totals the n slots in use, one
// read a cycle, then searches them slot by slot, each slot needing a store read and
// an accumulate before the compare; a zero total skips the search. This order of
// steps follows from the single read port of the weight store.
// Reset clears the sequencer, the output valid and population_count (to 64); the
// weight store holds no reset value. in_stall is high while a draw runs; a result
// held by out_stall parks the sequencer in its last step until the output frees.
module roulette_wheel_selector import rws_pkg::*; #(
	parameter int MAX_SLOTS   = MAX_SLOTS_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [POP_BITS-1:0]  cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic [SLOT_BITS-1:0] slot_index,
	input  logic [FIT_BITS-1:0]  fitness_weight,
	input  logic [DRAW_BITS-1:0] draw_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_BITS-1:0] selected_slot,
	output logic                 zero_total
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW = ($clog2(MAX_SLOTS + 1) > POP_BITS) ? $clog2(MAX_SLOTS + 1) : POP_BITS;
	localparam int TW = WEIGHT_BITS + AW;
	localparam int SW = DRAW_BITS + TW;

	step_t                 step_q;
	uword_t                uw;
	logic                  jump;
	logic                  accept_in;
	logic [POP_BITS-1:0]   pop_q;
	logic [NW-1:0]         pop_ext;
	logic [NW-1:0]         n_slots;
	logic [NW-1:0]         n_m1;
	logic [NW-1:0]         idx_q;
	logic [NW-1:0]         idx_p1;
	logic [TW-1:0]         total_q;
	logic [TW-1:0]         cum_q;
	logic [DRAW_BITS-1:0]  r_q;
	logic [SW-1:0]         target_q;
	logic [SW-1:0]         scaled;
	logic                  hit;
	logic                  tot_zero;
	logic                  rd_move;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WEIGHT_BITS-1:0] wr_data;
	logic [47:0]           fw_ext;
	logic [15:0]           slot_ext;
	logic [AW-1:0]         rd_addr;
	logic [WEIGHT_BITS-1:0] rd_data;
	logic                  out_valid_q;
	logic [SLOT_BITS-1:0]  sel_q;
	logic                  zero_q;

	assign uw        = ucode(step_q);
	assign in_stall  = !uw.in_ready;
	assign accept_in = in_valid && uw.in_ready;

	assign pop_ext  = NW'(pop_q);
	assign n_slots  = (pop_ext > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : pop_ext;
	assign n_m1     = n_slots - 1'b1;
	assign idx_p1   = idx_q + 1'b1;
	assign tot_zero = (total_q == '0);
	assign scaled   = SW'(cum_q) * SW'(DRAW_SCALE);
	assign hit      = (scaled >= target_q) || (idx_q == n_m1);

	always_comb begin
		unique case (uw.cond)
			C_DRAW:  jump = accept_in && (req_type == REQ_DRAW);
			C_EMPTY: jump = (n_slots == '0);
			C_LAST:  jump = (idx_q == n_slots);
			C_ZERO:  jump = tot_zero;
			C_HIT:   jump = hit;
			C_BUSY:  jump = out_valid_q && out_stall;
			default: jump = 1'b0;
		endcase
	end

	assign rd_move = !jump && (uw.rd_op == RD_POST || uw.rd_op == RD_PRE);
	assign rd_addr = (uw.rd_op == RD_PRE) ? idx_p1[AW-1:0] : idx_q[AW-1:0];

	// Weight writes land only from the idle step; drop slots past the store
	assign fw_ext   = 48'(fitness_weight);
	assign slot_ext = 16'(slot_index);
	assign wr_data  = fw_ext[WEIGHT_BITS-1:0];
	assign wr_addr  = slot_ext[AW-1:0];
	assign wr_en    = accept_in && (req_type == REQ_WRITE) && (32'(slot_index) < MAX_SLOTS);

	rws_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (MAX_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			pop_q       <= POP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= jump ? uw.jump_to : uw.next;
			if (cfg_wr_en) begin
				pop_q <= cfg_wr_data;
			end
			if (uw.out_load && !jump) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uw.in_ready || uw.tgt_load) begin
			idx_q <= '0;
		end else if (rd_move) begin
			idx_q <= idx_p1;
		end
		if (uw.in_ready) begin
			total_q <= '0;
		end else if (uw.tot_acc) begin
			total_q <= total_q + TW'(rd_data);
		end
		if (uw.tgt_load) begin
			cum_q    <= '0;
			target_q <= SW'(r_q) * SW'(total_q);
		end else if (uw.cum_acc) begin
			cum_q <= cum_q + TW'(rd_data);
		end
		if (accept_in && (req_type == REQ_DRAW)) begin
			r_q <= draw_value;
		end
		if (uw.out_load && !jump) begin
			sel_q  <= tot_zero ? '0 : idx_q[SLOT_BITS-1:0];
			zero_q <= tot_zero;
		end
	end

	assign out_valid     = out_valid_q;
	assign selected_slot = sel_q;
	assign zero_total    = zero_q;

	a_zero_pick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_q |-> sel_q == '0)
		else $error("zero total result names a slot other than 0");

	a_tot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_TOT_LOOP |-> idx_q <= n_slots && idx_q != '0)
		else $error("total walk left the slots in use");

	a_srch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_SRCH_CMP |-> idx_q < n_slots)
		else $error("search passed the last slot in use");

	a_srch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_SRCH_ACC |-> !tot_zero)
		else $error("search entered with a zero total");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_FINISH && !(out_valid_q && out_stall)
		|=> out_valid_q && step_q == ST_IDLE)
		else $error("finished draw did not post a result");

endmodule
